FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, idle while rst_n is low
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, idle while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ppm_pkg.sv
package ppm_pkg;

  // largest width or height taken by the header
  localparam int unsigned MAX_DIM = 65535;

  // field widths
  localparam int DIM_W = 16;
  localparam int SAMPLE_W = 16;
  localparam int ACC_W = 17;

  // result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW = $clog2(OUTQ_DEPTH);

  // parse phase
  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_DIGIT,
    PH_SEP,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXVAL,
    PH_ASCII,
    PH_RAW,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_MAGIC  = 3'd1,
    ERR_WIDTH  = 3'd2,
    ERR_HEIGHT = 3'd3,
    ERR_MAXVAL = 3'd4,
    ERR_SHORT  = 3'd5,
    ERR_RANGE  = 3'd6,
    ERR_CHAR   = 3'd7
  } err_t;

  // one result word
  typedef struct packed {
    kind_t               kind;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic                wide;
    logic [SAMPLE_W-1:0] sample;
    err_t                err;
    logic                done;
    logic                last;
  } res_t;

  // results produced by one input word, first then second
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

FILE: rtl/ppm_core.sv
`include "assert_macros.svh"

module ppm_core
  import ppm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       in_eof,
  output push_t      push
);

  // characters
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam logic [ACC_W-1:0] ACC_MAX   = '1;
  localparam logic [ACC_W-1:0] DIM_MAX   = ACC_W'(MAX_DIM);
  localparam logic [ACC_W-1:0] MAXVAL_8  = ACC_W'(255);
  localparam logic [ACC_W-1:0] MAXVAL_16 = ACC_W'(65535);
  localparam logic [1:0]       COMP_LAST = 2'd2;

  // parser state
  phase_t             phase_r, phase_nxt;
  logic               cmt_r, cmt_nxt;
  logic               ascii_r, ascii_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               dig_r, dig_nxt;
  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic               wide_r, wide_nxt;
  logic [1:0]         comp_r, comp_nxt;
  logic [DIM_W-1:0]   col_left_r, col_left_nxt;
  logic [DIM_W-1:0]   row_left_r, row_left_nxt;
  logic               hold_vld_r, hold_vld_nxt;
  logic [7:0]         hold_byte_r, hold_byte_nxt;

  // decisions of the current word
  logic                a_vld;
  kind_t               a_kind;
  err_t                a_err;
  logic [SAMPLE_W-1:0] a_sample;
  logic                a_done;
  logic                b_vld;
  err_t                b_err;
  logic [DIM_W-1:0]    res_width;
  logic [DIM_W-1:0]    res_height;
  logic                res_wide;

  res_t res_a, res_b;

  function automatic logic is_white(input logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_CR, CH_LF};
  endfunction

  // per-word step and next state
  always_comb begin
    logic [ACC_W+3:0]    prod;
    logic [ACC_W-1:0]    v;
    logic                close_req;
    logic                sample_req;
    logic [SAMPLE_W-1:0] sv;
    logic                is_digit;
    logic                last_comp;

    phase_nxt     = phase_r;
    cmt_nxt       = cmt_r;
    ascii_nxt     = ascii_r;
    acc_nxt       = acc_r;
    dig_nxt       = dig_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    wide_nxt      = wide_r;
    comp_nxt      = comp_r;
    col_left_nxt  = col_left_r;
    row_left_nxt  = row_left_r;
    hold_vld_nxt  = hold_vld_r;
    hold_byte_nxt = hold_byte_r;

    a_vld      = 1'b0;
    a_kind     = KIND_HEADER;
    a_err      = ERR_NONE;
    a_sample   = '0;
    a_done     = 1'b0;
    b_vld      = 1'b0;
    b_err      = ERR_NONE;
    res_width  = width_r;
    res_height = height_r;
    res_wide   = wide_r;

    close_req  = 1'b0;
    sample_req = 1'b0;
    sv         = '0;
    v          = acc_r;
    last_comp  = 1'b0;
    is_digit   = in_byte inside {[CH_0:CH_9]};
    prod       = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                 {13'd0, in_byte - CH_0};

    if (in_fire) begin
      // byte itself
      case (phase_r)
        PH_MAGIC: begin
          if (cmt_r) begin
            if (in_byte == CH_LF) cmt_nxt = 1'b0;
          end else if (is_white(in_byte)) begin
            cmt_nxt = 1'b0;
          end else if (in_byte == CH_HASH) begin
            cmt_nxt = 1'b1;
          end else if (in_byte == CH_P) begin
            phase_nxt = PH_DIGIT;
          end else begin
            a_vld = 1'b1; a_kind = KIND_ERROR; a_err = ERR_MAGIC;
            phase_nxt = PH_ERROR;
          end
        end
        PH_DIGIT: begin
          if (in_byte == CH_3) begin
            ascii_nxt = 1'b1; phase_nxt = PH_SEP;
          end else if (in_byte == CH_6) begin
            ascii_nxt = 1'b0; phase_nxt = PH_SEP;
          end else begin
            a_vld = 1'b1; a_kind = KIND_ERROR; a_err = ERR_MAGIC;
            phase_nxt = PH_ERROR;
          end
        end
        PH_SEP: begin
          if (is_white(in_byte)) begin
            phase_nxt = PH_WIDTH;
          end else if (in_byte == CH_HASH) begin
            cmt_nxt = 1'b1; phase_nxt = PH_WIDTH;
          end else begin
            a_vld = 1'b1; a_kind = KIND_ERROR; a_err = ERR_CHAR;
            phase_nxt = PH_ERROR;
          end
        end
        PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII: begin
          if (cmt_r) begin
            if (in_byte == CH_LF) cmt_nxt = 1'b0;
          end else if (is_digit) begin
            acc_nxt = (prod > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : prod[ACC_W-1:0];
            dig_nxt = 1'b1;
          end else if (is_white(in_byte)) begin
            close_req = dig_r;
          end else if (in_byte == CH_HASH && !dig_r &&
                       (phase_r == PH_WIDTH || phase_r == PH_MAXVAL)) begin
            cmt_nxt = 1'b1;
          end else begin
            a_vld = 1'b1; a_kind = KIND_ERROR; a_err = ERR_CHAR;
            phase_nxt = PH_ERROR;
          end
        end
        PH_RAW: begin
          if (!wide_r) begin
            sample_req = 1'b1; sv = {8'd0, in_byte};
          end else if (hold_vld_r) begin
            sample_req = 1'b1; sv = {hold_byte_r, in_byte};
            hold_vld_nxt = 1'b0;
          end else begin
            hold_vld_nxt  = 1'b1;
            hold_byte_nxt = in_byte;
          end
        end
        default: begin
        end
      endcase

      // end of file closes an open number
      if (in_eof && dig_nxt && (phase_nxt inside {PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII}))
        close_req = 1'b1;

      // number complete
      if (close_req) begin
        v       = acc_nxt;
        acc_nxt = '0;
        dig_nxt = 1'b0;
        case (phase_nxt)
          PH_WIDTH: begin
            if (v == '0 || v > DIM_MAX) begin
              a_vld = 1'b1; a_kind = KIND_ERROR; a_err = ERR_WIDTH;
              phase_nxt = PH_ERROR;
            end else begin
              width_nxt = v[DIM_W-1:0];
              phase_nxt = PH_HEIGHT;
            end
          end
          PH_HEIGHT: begin
            if (v == '0 || v > DIM_MAX) begin
              a_vld = 1'b1; a_kind = KIND_ERROR; a_err = ERR_HEIGHT;
              phase_nxt = PH_ERROR;
            end else begin
              height_nxt = v[DIM_W-1:0];
              phase_nxt  = PH_MAXVAL;
            end
          end
          PH_MAXVAL: begin
            if (v == MAXVAL_8 || v == MAXVAL_16) begin
              wide_nxt     = (v == MAXVAL_16);
              a_vld        = 1'b1;
              a_kind       = KIND_HEADER;
              comp_nxt     = '0;
              col_left_nxt = width_r;
              row_left_nxt = height_r;
              phase_nxt    = ascii_r ? PH_ASCII : PH_RAW;
            end else begin
              a_vld = 1'b1; a_kind = KIND_ERROR; a_err = ERR_MAXVAL;
              phase_nxt = PH_ERROR;
            end
          end
          PH_ASCII: begin
            if (v > (wide_r ? MAXVAL_16 : MAXVAL_8)) begin
              a_vld = 1'b1; a_kind = KIND_ERROR; a_err = ERR_RANGE;
              phase_nxt = PH_ERROR;
            end else begin
              sample_req = 1'b1;
              sv = v[SAMPLE_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end

      // sample out, walk component / column / row
      if (sample_req) begin
        last_comp = (comp_r == COMP_LAST) && (col_left_r == DIM_W'(1)) &&
                    (row_left_r == DIM_W'(1));
        a_vld    = 1'b1;
        a_kind   = KIND_SAMPLE;
        a_sample = sv;
        a_done   = last_comp;
        if (last_comp) begin
          phase_nxt = PH_DONE;
        end else if (comp_r == COMP_LAST) begin
          comp_nxt = '0;
          if (col_left_r == DIM_W'(1)) begin
            col_left_nxt = width_r;
            row_left_nxt = row_left_r - 1'b1;
          end else begin
            col_left_nxt = col_left_r - 1'b1;
          end
        end else begin
          comp_nxt = comp_r + 1'b1;
        end
      end

      // header fields as they stand after this word
      res_width  = width_nxt;
      res_height = height_nxt;
      res_wide   = wide_nxt;

      // end of file: report an unfinished image, then rearm
      if (in_eof) begin
        b_vld = 1'b1;
        case (phase_nxt)
          PH_MAGIC, PH_DIGIT: b_err = ERR_MAGIC;
          PH_SEP, PH_WIDTH:   b_err = ERR_WIDTH;
          PH_HEIGHT:          b_err = ERR_HEIGHT;
          PH_MAXVAL:          b_err = ERR_MAXVAL;
          PH_ASCII, PH_RAW:   b_err = ERR_SHORT;
          default:            b_vld = 1'b0;
        endcase
        phase_nxt    = PH_MAGIC;
        cmt_nxt      = 1'b0;
        ascii_nxt    = 1'b0;
        acc_nxt      = '0;
        dig_nxt      = 1'b0;
        width_nxt    = '0;
        height_nxt   = '0;
        wide_nxt     = 1'b0;
        comp_nxt     = '0;
        col_left_nxt = '0;
        row_left_nxt = '0;
        hold_vld_nxt = 1'b0;
      end
    end
  end

  // result words
  always_comb begin
    res_a.kind   = a_kind;
    res_a.width  = res_width;
    res_a.height = res_height;
    res_a.wide   = res_wide;
    res_a.sample = a_sample;
    res_a.err    = a_err;
    res_a.done   = a_done;
    res_a.last   = !b_vld;

    res_b.kind   = KIND_ERROR;
    res_b.width  = res_width;
    res_b.height = res_height;
    res_b.wide   = res_wide;
    res_b.sample = '0;
    res_b.err    = b_err;
    res_b.done   = 1'b0;
    res_b.last   = 1'b1;

    push.cnt    = {1'b0, a_vld} + {1'b0, b_vld};
    push.first  = a_vld ? res_a : res_b;
    push.second = res_b;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MAGIC;
      cmt_r      <= 1'b0;
      ascii_r    <= 1'b0;
      acc_r      <= '0;
      dig_r      <= 1'b0;
      width_r    <= '0;
      height_r   <= '0;
      wide_r     <= 1'b0;
      comp_r     <= '0;
      col_left_r <= '0;
      row_left_r <= '0;
      hold_vld_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cmt_r      <= cmt_nxt;
      ascii_r    <= ascii_nxt;
      acc_r      <= acc_nxt;
      dig_r      <= dig_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      wide_r     <= wide_nxt;
      comp_r     <= comp_nxt;
      col_left_r <= col_left_nxt;
      row_left_r <= row_left_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

  // held high byte of a wide raw sample
  always_ff @(posedge clk) begin
    hold_byte_r <= hold_byte_nxt;
  end

  // checks
  `ASSERT_NEXT(a_eof_rearm, in_fire && in_eof, phase_r == PH_MAGIC && !dig_r && !hold_vld_r, "parser not rearmed after end of file")
  `ASSERT_IMPLY(a_two_res, push.cnt == 2'd2, in_fire && in_eof && push.second.kind == KIND_ERROR, "second result without end of file error")
  `ASSERT_NEXT(a_done_park, push.cnt != 2'd0 && push.first.kind == KIND_SAMPLE && push.first.done && !in_eof, phase_r == PH_DONE, "last sample did not close the image")

endmodule

FILE: rtl/ppm_outq.sv
`include "assert_macros.svh"

module ppm_outq
  import ppm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  space,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t                mem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_AW:0]    cnt_r, cnt_nxt;
  logic [OUTQ_AW-1:0]  wr_ptr_p1;
  logic                pop;

  // read side
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // room for the two words one input word may cause
  assign space = (cnt_r <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2));

  // pointers and fill count
  always_comb begin
    wr_ptr_p1  = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + push.cnt[OUTQ_AW-1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{(OUTQ_AW-1){1'b0}}, push.cnt} - {{OUTQ_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.first;
    if (push.cnt == 2'd2) mem_r[wr_ptr_p1] <= push.second;
  end

  // checks
  `ASSERT_IMPLY(a_q_bound, 1'b1, cnt_r <= (OUTQ_AW+1)'(OUTQ_DEPTH), "result queue overfilled")
  `ASSERT_IMPLY(a_q_room, push.cnt != 2'd0, space, "word pushed without room")
  `ASSERT_NEXT(a_q_keep, out_valid && !out_ready && push.cnt == 2'd0, out_valid && out_res == $past(out_res), "stalled result changed")

endmodule

FILE: rtl/ppm_stream_parser.sv
// PPM (P3 / P6) byte stream parser. Takes one file byte per cycle while the
// result queue has room, and returns a header word once width, height and
// maxval are checked, then one word per colour component in R G B order, and
// an error word on any failure; after an error or a finished image, bytes are
// dropped until the byte marked end of file, which always rearms the parser
// for the next file. A byte causes at most two words (the second only with end
// of file), which are registered into the result queue behind any words
// already queued. The four-word result queue holds back in_ready only while
// fewer than two of its entries are free.
module ppm_stream_parser
  import ppm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_end_of_file,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [DIM_W-1:0]    out_img_width,
  output logic [DIM_W-1:0]    out_image_height,
  output logic                out_sixteen_bit,
  output logic [SAMPLE_W-1:0] out_sample_value,
  output logic [2:0]          out_error_code,
  output logic                out_image_done,
  output logic                out_run_last
);

  logic  in_fire;
  logic  space;
  push_t push;
  res_t  out_res;

  // input handshake
  assign in_ready = space;
  assign in_fire  = in_valid && in_ready;

  // parser
  ppm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_data_byte),
    .in_eof  (in_end_of_file),
    .push    (push)
  );

  // result queue
  ppm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // result fields
  assign out_kind         = out_res.kind;
  assign out_img_width    = out_res.width;
  assign out_image_height = out_res.height;
  assign out_sixteen_bit  = out_res.wide;
  assign out_sample_value = out_res.sample;
  assign out_error_code   = out_res.err;
  assign out_image_done   = out_res.done;
  assign out_run_last     = out_res.last;

endmodule
